>>> hdl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg - relative strength index shared definitions
// Widths, constants, microcode word layout and the control program.
// ----------------------------------------------------------------------------
package rsi_pkg;

   localparam int PRICE_W      = 32;
   localparam int LEN_W        = 10;
   localparam int CNT_W        = 11;
   localparam int AVG_W        = 64;
   localparam int RSI_W        = 15;
   localparam int PC_W         = 5;
   localparam int LDIV_BITS    = 4;
   localparam int NARROW_BITS  = 48;
   localparam int NARROW_SPAN  = AVG_W - NARROW_BITS;
   localparam int SHIFT_W      = 5;

   localparam int PRICE_BITS_DEF    = 32;
   localparam int FRACTION_BITS_DEF = 16;

   localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(14);
   localparam logic [RSI_W-1:0] RSI_FULL     = RSI_W'(25600);

   // 25600 = 2^14 + 2^13 + 2^10
   localparam int MUL_SH_A = 14;
   localparam int MUL_SH_B = 13;
   localparam int MUL_SH_C = 10;

   typedef logic [PC_W-1:0] rsi_pc_type;

   typedef enum logic [4:0] {
      UOP_NOP,
      UOP_DIFF,
      UOP_ACC,
      UOP_LD_AVG_G,
      UOP_LD_AVG_L,
      UOP_LDIV,
      UOP_WB_AVG_G,
      UOP_WB_AVG_L,
      UOP_SM_DIFF_G,
      UOP_SM_DIFF_L,
      UOP_SM_BIAS,
      UOP_LD_SM,
      UOP_WB_SM_G,
      UOP_WB_SM_L,
      UOP_NARROW,
      UOP_SUM,
      UOP_MUL1,
      UOP_MUL2,
      UOP_IDIV,
      UOP_RSI_WB,
      UOP_RSI_ZERO,
      UOP_COMMIT
   } rsi_uop_type;

   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_IDLE,
      CND_REF,
      CND_SMOOTH,
      CND_NOT_END,
      CND_LOOP,
      CND_RSP_FREE
   } rsi_cond_type;

   typedef enum logic [1:0] {
      LP_NONE,
      LP_AVG,
      LP_SMOOTH,
      LP_INDEX
   } rsi_loop_type;

   typedef struct packed {
      rsi_uop_type  uop;
      rsi_cond_type cond;
      rsi_loop_type loop;
      rsi_pc_type   target;
   } rsi_uword_type;

   typedef struct packed {
      rsi_uop_type uop;
      logic        take;
   } rsi_ctrl_type;

   typedef struct packed {
      logic ref_phase;
      logic smooth_phase;
      logic not_end;
      logic rsp_free;
   } rsi_status_type;

   localparam rsi_pc_type ST_WAIT    = PC_W'(0);
   localparam rsi_pc_type ST_DIFF    = PC_W'(1);
   localparam rsi_pc_type ST_BRANCH  = PC_W'(2);
   localparam rsi_pc_type ST_ACC     = PC_W'(3);
   localparam rsi_pc_type ST_AG_LD   = PC_W'(4);
   localparam rsi_pc_type ST_AG_RUN  = PC_W'(5);
   localparam rsi_pc_type ST_AG_WB   = PC_W'(6);
   localparam rsi_pc_type ST_AL_LD   = PC_W'(7);
   localparam rsi_pc_type ST_AL_RUN  = PC_W'(8);
   localparam rsi_pc_type ST_AL_WB   = PC_W'(9);
   localparam rsi_pc_type ST_SG_DIFF = PC_W'(10);
   localparam rsi_pc_type ST_SG_BIAS = PC_W'(11);
   localparam rsi_pc_type ST_SG_LD   = PC_W'(12);
   localparam rsi_pc_type ST_SG_RUN  = PC_W'(13);
   localparam rsi_pc_type ST_SG_WB   = PC_W'(14);
   localparam rsi_pc_type ST_SL_DIFF = PC_W'(15);
   localparam rsi_pc_type ST_SL_BIAS = PC_W'(16);
   localparam rsi_pc_type ST_SL_LD   = PC_W'(17);
   localparam rsi_pc_type ST_SL_RUN  = PC_W'(18);
   localparam rsi_pc_type ST_SL_WB   = PC_W'(19);
   localparam rsi_pc_type ST_IX_NAR  = PC_W'(20);
   localparam rsi_pc_type ST_IX_SUM  = PC_W'(21);
   localparam rsi_pc_type ST_IX_MUL1 = PC_W'(22);
   localparam rsi_pc_type ST_IX_MUL2 = PC_W'(23);
   localparam rsi_pc_type ST_IX_RUN  = PC_W'(24);
   localparam rsi_pc_type ST_IX_WB   = PC_W'(25);
   localparam rsi_pc_type ST_FIN_W   = PC_W'(26);
   localparam rsi_pc_type ST_FIN     = PC_W'(27);
   localparam rsi_pc_type ST_STALL   = PC_W'(28);

   function automatic rsi_uword_type uw(input rsi_uop_type uop, input rsi_cond_type cond,
                                        input rsi_loop_type loop, input rsi_pc_type target);
      rsi_uword_type w;
      w.uop    = uop;
      w.cond   = cond;
      w.loop   = loop;
      w.target = target;
      return w;
   endfunction

   function automatic rsi_uword_type rsi_ucode(input rsi_pc_type pc);
      rsi_uword_type w;
      unique case (pc)
         ST_WAIT:    w = uw(UOP_NOP,       CND_IDLE,     LP_NONE,   ST_WAIT);
         ST_DIFF:    w = uw(UOP_DIFF,      CND_REF,      LP_NONE,   ST_FIN_W);
         ST_BRANCH:  w = uw(UOP_NOP,       CND_SMOOTH,   LP_NONE,   ST_SG_DIFF);
         ST_ACC:     w = uw(UOP_ACC,       CND_NOT_END,  LP_NONE,   ST_FIN_W);
         ST_AG_LD:   w = uw(UOP_LD_AVG_G,  CND_NEVER,    LP_AVG,    ST_WAIT);
         ST_AG_RUN:  w = uw(UOP_LDIV,      CND_LOOP,     LP_NONE,   ST_AG_RUN);
         ST_AG_WB:   w = uw(UOP_WB_AVG_G,  CND_NEVER,    LP_NONE,   ST_WAIT);
         ST_AL_LD:   w = uw(UOP_LD_AVG_L,  CND_NEVER,    LP_AVG,    ST_WAIT);
         ST_AL_RUN:  w = uw(UOP_LDIV,      CND_LOOP,     LP_NONE,   ST_AL_RUN);
         ST_AL_WB:   w = uw(UOP_WB_AVG_L,  CND_ALWAYS,   LP_NONE,   ST_FIN_W);
         ST_SG_DIFF: w = uw(UOP_SM_DIFF_G, CND_NEVER,    LP_NONE,   ST_WAIT);
         ST_SG_BIAS: w = uw(UOP_SM_BIAS,   CND_NEVER,    LP_NONE,   ST_WAIT);
         ST_SG_LD:   w = uw(UOP_LD_SM,     CND_NEVER,    LP_SMOOTH, ST_WAIT);
         ST_SG_RUN:  w = uw(UOP_LDIV,      CND_LOOP,     LP_NONE,   ST_SG_RUN);
         ST_SG_WB:   w = uw(UOP_WB_SM_G,   CND_NEVER,    LP_NONE,   ST_WAIT);
         ST_SL_DIFF: w = uw(UOP_SM_DIFF_L, CND_NEVER,    LP_NONE,   ST_WAIT);
         ST_SL_BIAS: w = uw(UOP_SM_BIAS,   CND_NEVER,    LP_NONE,   ST_WAIT);
         ST_SL_LD:   w = uw(UOP_LD_SM,     CND_NEVER,    LP_SMOOTH, ST_WAIT);
         ST_SL_RUN:  w = uw(UOP_LDIV,      CND_LOOP,     LP_NONE,   ST_SL_RUN);
         ST_SL_WB:   w = uw(UOP_WB_SM_L,   CND_NEVER,    LP_NONE,   ST_WAIT);
         ST_IX_NAR:  w = uw(UOP_NARROW,    CND_NEVER,    LP_NONE,   ST_WAIT);
         ST_IX_SUM:  w = uw(UOP_SUM,       CND_NEVER,    LP_NONE,   ST_WAIT);
         ST_IX_MUL1: w = uw(UOP_MUL1,      CND_NEVER,    LP_NONE,   ST_WAIT);
         ST_IX_MUL2: w = uw(UOP_MUL2,      CND_NEVER,    LP_INDEX,  ST_WAIT);
         ST_IX_RUN:  w = uw(UOP_IDIV,      CND_LOOP,     LP_NONE,   ST_IX_RUN);
         ST_IX_WB:   w = uw(UOP_RSI_WB,    CND_ALWAYS,   LP_NONE,   ST_FIN);
         ST_FIN_W:   w = uw(UOP_RSI_ZERO,  CND_NEVER,    LP_NONE,   ST_WAIT);
         ST_FIN:     w = uw(UOP_COMMIT,    CND_RSP_FREE, LP_NONE,   ST_WAIT);
         ST_STALL:   w = uw(UOP_NOP,       CND_ALWAYS,   LP_NONE,   ST_FIN);
         default:    w = uw(UOP_NOP,       CND_ALWAYS,   LP_NONE,   ST_WAIT);
      endcase
      return w;
   endfunction

endpackage

>>> hdl/rsi_if.sv
// ----------------------------------------------------------------------------
// rsi_if - item channels
// Price request channel and index response channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsi_req_if;
   import rsi_pkg::*;

   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] price;
   logic               last_of_series;

   modport source (output valid, output price, output last_of_series, input ready);
   modport sink   (input valid, input price, input last_of_series, output ready);
endinterface

interface rsi_rsp_if;
   import rsi_pkg::*;

   logic             valid;
   logic             ready;
   logic [RSI_W-1:0] rsi_value;
   logic             value_valid;

   modport source (output valid, output rsi_value, output value_valid, input ready);
   modport sink   (input valid, input rsi_value, input value_valid, output ready);
endinterface

>>> hdl/rsi_seq.sv
// ----------------------------------------------------------------------------
// rsi_seq - microcode sequencer
// Step counter, program table lookup, loop counter and conditional jumps.
// ----------------------------------------------------------------------------
module rsi_seq #(
   parameter int AVG_STEPS = 20,
   parameter int SM_STEPS  = 16,
   parameter int IX_STEPS  = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rsi_pkg::rsi_status_type status,
   output rsi_pkg::rsi_ctrl_type   ctrl
);
   import rsi_pkg::*;

   localparam int LC_W = $clog2(AVG_STEPS);

   rsi_pc_type      pc_ff;
   rsi_pc_type      pc_in;
   logic [LC_W-1:0] lc_ff;
   logic [LC_W-1:0] lc_in;
   rsi_uword_type   word;
   logic            taken;

   assign word      = rsi_ucode(pc_ff);
   assign req_ready = (pc_ff == ST_WAIT);
   assign ctrl.uop  = word.uop;
   assign ctrl.take = req_ready && req_valid;

   always_comb begin
      unique case (word.cond)
         CND_NEVER:    taken = 1'b0;
         CND_ALWAYS:   taken = 1'b1;
         CND_IDLE:     taken = !req_valid;
         CND_REF:      taken = status.ref_phase;
         CND_SMOOTH:   taken = status.smooth_phase;
         CND_NOT_END:  taken = status.not_end;
         CND_LOOP:     taken = (lc_ff != '0);
         CND_RSP_FREE: taken = status.rsp_free;
         default:      taken = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = taken ? word.target : pc_ff + PC_W'(1);
   end

   always_comb begin
      lc_in = lc_ff;
      unique case (word.loop)
         LP_AVG:    lc_in = LC_W'(AVG_STEPS - 1);
         LP_SMOOTH: lc_in = LC_W'(SM_STEPS - 1);
         LP_INDEX:  lc_in = LC_W'(IX_STEPS - 1);
         default: begin
            if (word.cond == CND_LOOP && lc_ff != '0) begin
               lc_in = lc_ff - LC_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_WAIT;
         lc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
         lc_ff <= lc_in;
      end
   end

endmodule

>>> hdl/rsi_ldiv.sv
// ----------------------------------------------------------------------------
// rsi_ldiv - long division by the window length
// Shift register dividend/quotient, narrow remainder, several bits per cycle.
// ----------------------------------------------------------------------------
module rsi_ldiv #(
   parameter int QW = 80
) (
   input  logic                      clock,
   input  logic                      load,
   input  logic [QW-1:0]             load_value,
   input  logic                      step,
   input  logic [rsi_pkg::LEN_W-1:0] divisor,
   output logic [QW-1:0]             quotient
);
   import rsi_pkg::*;

   logic [QW-1:0]    q_ff;
   logic [QW-1:0]    q_in;
   logic [LEN_W-1:0] rem_ff;
   logic [LEN_W-1:0] rem_in;
   logic [LEN_W:0]   trial;

   assign quotient = q_ff;

   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      trial  = '0;
      if (load) begin
         q_in   = load_value;
         rem_in = '0;
      end else if (step) begin
         for (int j = 0; j < LDIV_BITS; j++) begin
            trial = {rem_in, q_in[QW-1]};
            q_in  = {q_in[QW-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               trial   = trial - {1'b0, divisor};
               q_in[0] = 1'b1;
            end
            rem_in = trial[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

endmodule

>>> hdl/rsi_dp.sv
// ----------------------------------------------------------------------------
// rsi_dp - index datapath
// Series state, working registers, index divider and the response register.
// ----------------------------------------------------------------------------
module rsi_dp #(
   parameter int PRICE_BITS    = 32,
   parameter int FRACTION_BITS = 16,
   parameter int QW            = 80
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rsi_pkg::rsi_ctrl_type       ctrl,
   output rsi_pkg::rsi_status_type     status,
   input  logic [rsi_pkg::LEN_W-1:0]   len,
   input  logic [rsi_pkg::PRICE_W-1:0] req_price,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rsi_pkg::RSI_W-1:0]   rsp_rsi_value,
   output logic                        rsp_value_valid
);
   import rsi_pkg::*;

   localparam int PW    = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
   localparam int FBPAD = QW - AVG_W;

   logic [PW-1:0]    price_ff, price_in;
   logic             last_ff, last_in;
   logic [PW-1:0]    prev_ff, prev_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [AVG_W-1:0] gain_ff, gain_in;
   logic [AVG_W-1:0] loss_ff, loss_in;
   logic [PW-1:0]    gx_ff, gx_in;
   logic [PW-1:0]    lx_ff, lx_in;
   logic [AVG_W-1:0] t_ff, t_in;
   logic             up_ff, up_in;
   logic [AVG_W-1:0] dv_ff, dv_in;
   logic [AVG_W-1:0] n_ff, n_in;
   logic [RSI_W-1:0] q_ff, q_in;
   logic             full_ff, full_in;
   logic [RSI_W-1:0] res_rsi_ff, res_rsi_in;
   logic             res_vv_ff, res_vv_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSI_W-1:0] rsp_rsi_ff, rsp_rsi_in;
   logic             rsp_vv_ff, rsp_vv_in;

   logic [AVG_W:0]       acc_g, acc_l;
   logic [AVG_W-1:0]     gx_fix, lx_fix, sm_x, sm_a;
   logic [NARROW_SPAN-1:0] hi;
   logic [SHIFT_W-1:0]   k;
   logic                 ge;
   logic                 ld_en, step_en;
   logic [QW-1:0]        ld_value;
   logic [QW-1:0]        quo;
   logic [CNT_W-1:0]     len_ext;
   logic                 commit;

   assign len_ext = CNT_W'(len);
   assign gx_fix  = AVG_W'(gx_ff) << FRACTION_BITS;
   assign lx_fix  = AVG_W'(lx_ff) << FRACTION_BITS;
   assign acc_g   = {1'b0, gain_ff} + (AVG_W+1)'(gx_ff);
   assign acc_l   = {1'b0, loss_ff} + (AVG_W+1)'(lx_ff);
   assign hi      = gain_ff[AVG_W-1:NARROW_BITS] | loss_ff[AVG_W-1:NARROW_BITS];

   assign status.ref_phase    = (cnt_ff == '0);
   assign status.smooth_phase = (cnt_ff > len_ext);
   assign status.not_end      = (cnt_ff != len_ext);
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign commit = (ctrl.uop == UOP_COMMIT) && status.rsp_free;

   assign ld_en   = (ctrl.uop == UOP_LD_AVG_G) || (ctrl.uop == UOP_LD_AVG_L) ||
                    (ctrl.uop == UOP_LD_SM);
   assign step_en = (ctrl.uop == UOP_LDIV);

   always_comb begin
      ld_value = {t_ff, {FBPAD{1'b0}}};
      if (ctrl.uop == UOP_LD_AVG_G) begin
         ld_value = QW'(gain_ff) << FRACTION_BITS;
      end else if (ctrl.uop == UOP_LD_AVG_L) begin
         ld_value = QW'(loss_ff) << FRACTION_BITS;
      end
   end

   rsi_ldiv #(
      .QW (QW)
   ) u_ldiv (
      .clock      (clock),
      .load       (ld_en),
      .load_value (ld_value),
      .step       (step_en),
      .divisor    (len),
      .quotient   (quo)
   );

   always_comb begin
      k = '0;
      for (int i = 0; i < NARROW_SPAN; i++) begin
         if (hi[i]) begin
            k = SHIFT_W'(i + 1);
         end
      end
   end

   always_comb begin
      sm_x = (ctrl.uop == UOP_SM_DIFF_L) ? lx_fix : gx_fix;
      sm_a = (ctrl.uop == UOP_SM_DIFF_L) ? loss_ff : gain_ff;
      ge   = (ctrl.uop == UOP_IDIV) ? (n_ff >= dv_ff) : (sm_x >= sm_a);
   end

   always_comb begin
      price_in     = price_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      gain_in      = gain_ff;
      loss_in      = loss_ff;
      gx_in        = gx_ff;
      lx_in        = lx_ff;
      t_in         = t_ff;
      up_in        = up_ff;
      dv_in        = dv_ff;
      n_in         = n_ff;
      q_in         = q_ff;
      full_in      = full_ff;
      res_rsi_in   = res_rsi_ff;
      res_vv_in    = res_vv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rsi_in   = rsp_rsi_ff;
      rsp_vv_in    = rsp_vv_ff;

      if (ctrl.take) begin
         price_in = req_price[PW-1:0];
         last_in  = req_last;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (ctrl.uop)
         UOP_DIFF: begin
            gx_in = (price_ff > prev_ff) ? price_ff - prev_ff : '0;
            lx_in = (price_ff > prev_ff) ? '0 : prev_ff - price_ff;
         end
         UOP_ACC: begin
            gain_in = acc_g[AVG_W] ? '1 : acc_g[AVG_W-1:0];
            loss_in = acc_l[AVG_W] ? '1 : acc_l[AVG_W-1:0];
         end
         UOP_WB_AVG_G: gain_in = (|quo[QW-1:AVG_W]) ? '1 : quo[AVG_W-1:0];
         UOP_WB_AVG_L: loss_in = (|quo[QW-1:AVG_W]) ? '1 : quo[AVG_W-1:0];
         UOP_SM_DIFF_G, UOP_SM_DIFF_L: begin
            up_in = ge;
            t_in  = ge ? sm_x - sm_a : sm_a - sm_x;
         end
         UOP_SM_BIAS: begin
            if (!up_ff) begin
               t_in = t_ff + AVG_W'(len - LEN_W'(1));
            end
         end
         UOP_WB_SM_G: begin
            gain_in = up_ff ? gain_ff + quo[AVG_W-1:0] : gain_ff - quo[AVG_W-1:0];
         end
         UOP_WB_SM_L: begin
            loss_in = up_ff ? loss_ff + quo[AVG_W-1:0] : loss_ff - quo[AVG_W-1:0];
         end
         UOP_NARROW: begin
            t_in    = gain_ff >> k;
            dv_in   = loss_ff >> k;
            full_in = (loss_ff == '0);
         end
         UOP_SUM:  dv_in = (t_ff + dv_ff) << (RSI_W - 1);
         UOP_MUL1: n_in  = (t_ff << MUL_SH_A) + (t_ff << MUL_SH_B);
         UOP_MUL2: n_in  = n_ff + (t_ff << MUL_SH_C);
         UOP_IDIV: begin
            n_in  = ge ? n_ff - dv_ff : n_ff;
            dv_in = dv_ff >> 1;
            q_in  = {q_ff[RSI_W-2:0], ge};
         end
         UOP_RSI_WB: begin
            res_rsi_in = full_ff ? RSI_FULL : q_ff;
            res_vv_in  = 1'b1;
         end
         UOP_RSI_ZERO: begin
            res_rsi_in = '0;
            res_vv_in  = 1'b0;
         end
         UOP_COMMIT: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_rsi_in   = res_rsi_ff;
               rsp_vv_in    = res_vv_ff;
               prev_in      = price_ff;
               if (cnt_ff <= len_ext) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (last_ff) begin
                  prev_in = '0;
                  cnt_in  = '0;
                  gain_in = '0;
                  loss_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         cnt_ff       <= '0;
         gain_ff      <= '0;
         loss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         cnt_ff       <= cnt_in;
         gain_ff      <= gain_in;
         loss_ff      <= loss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff   <= price_in;
      last_ff    <= last_in;
      gx_ff      <= gx_in;
      lx_ff      <= lx_in;
      t_ff       <= t_in;
      up_ff      <= up_in;
      dv_ff      <= dv_in;
      n_ff       <= n_in;
      q_ff       <= q_in;
      full_ff    <= full_in;
      res_rsi_ff <= res_rsi_in;
      res_vv_ff  <= res_vv_in;
      rsp_rsi_ff <= rsp_rsi_in;
      rsp_vv_ff  <= rsp_vv_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rsi_value   = rsp_rsi_ff;
   assign rsp_value_valid = rsp_vv_ff;

endmodule

>>> hdl/relative_strength_index_top.sv
// ----------------------------------------------------------------------------
// relative_strength_index_top - Wilder relative strength index
// One price sample in, one index value out, microcoded over a shared datapath.
//
//   channel   direction  handshake            contents
//   req_if    in         valid/ready          price, last_of_series
//   rsp_if    out        valid/ready          rsi_value, value_valid
//   csr_*     in         csr_wr_en            window_length
//
// Work per item depends on its phase: the reference sample, a warm-up
// sample, the sample closing warm-up (both window averages) and each
// smoothed sample (both smoothing divisions, then the index division); the
// long division by the window (four quotient bits per cycle) serves both.
// Reset is synchronous and needs no clearing pass. A result waits in the
// response register; the next item is taken meanwhile and holds at its final
// step until that register frees up.
// ----------------------------------------------------------------------------
module relative_strength_index_top #(
   parameter int PRICE_BITS    = rsi_pkg::PRICE_BITS_DEF,
   parameter int FRACTION_BITS = rsi_pkg::FRACTION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   rsi_req_if.sink                   req_if,
   rsi_rsp_if.source                 rsp_if,
   input  logic                      csr_wr_en,
   input  logic [rsi_pkg::LEN_W-1:0] csr_wr_data
);
   import rsi_pkg::*;

   localparam int FBPAD     = ((FRACTION_BITS + LDIV_BITS - 1) / LDIV_BITS) * LDIV_BITS;
   localparam int QW        = AVG_W + FBPAD;
   localparam int AVG_STEPS = QW / LDIV_BITS;
   localparam int SM_STEPS  = AVG_W / LDIV_BITS;
   localparam int IX_STEPS  = RSI_W;

   logic [LEN_W-1:0] window_length_ff;
   logic [LEN_W-1:0] window_length_in;
   logic [LEN_W-1:0] len;
   rsi_ctrl_type     ctrl;
   rsi_status_type   status;

   assign window_length_in = csr_wr_en ? csr_wr_data : window_length_ff;
   assign len = (window_length_ff == '0) ? LEN_W'(1) : window_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
      end else begin
         window_length_ff <= window_length_in;
      end
   end

   rsi_seq #(
      .AVG_STEPS (AVG_STEPS),
      .SM_STEPS  (SM_STEPS),
      .IX_STEPS  (IX_STEPS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   rsi_dp #(
      .PRICE_BITS    (PRICE_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .QW            (QW)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .len             (len),
      .req_price       (req_if.price),
      .req_last        (req_if.last_of_series),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_rsi_value   (rsp_if.rsi_value),
      .rsp_value_valid (rsp_if.value_valid)
   );

   a_warmup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.value_valid |-> rsp_if.rsi_value == '0)
      else $error("warm-up result carries a nonzero index");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.rsi_value <= RSI_FULL)
      else $error("index above full scale");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("new item taken while the previous one is in work");

endmodule

>>> tb/relative_strength_index_top_test.sv
// ----------------------------------------------------------------------------
// relative_strength_index_top_test - RSI engine self-checking testbench
// Streams price series through the request channel and predicts every index
// value in step with each accepted item. Window settings change between
// phases after draining. Both channels idle in random bursts in most phases.
// ----------------------------------------------------------------------------
module relative_strength_index_top_test;
   import rsi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC        = FRACTION_BITS_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam logic [AVG_W-1:0] NARROW_LIMIT = AVG_W'(1) << NARROW_BITS;
   localparam int unsigned WINDOW_PLAN [11] = '{0, 2, 1023, 3, 5, 14, 7, 40, 1, 9, 2};

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic               last_of_series;
   } price_item_type;

   typedef struct packed {
      logic [RSI_W-1:0] rsi_value;
      logic             value_valid;
   } index_result_type;

   typedef enum {WALK, SCATTER, CLIMB, SLIDE} price_trend_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [LEN_W-1:0]  csr_wr_data;

   rsi_req_if req_bus ();
   rsi_rsp_if rsp_bus ();

   relative_strength_index_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   price_item_type   price_queue [$];
   index_result_type rsi_expected [$];
   price_item_type   on_wire;
   index_result_type predicted;
   index_result_type oldest;

   logic [LEN_W-1:0]   window_len   = WINDOW_RESET;
   logic [PRICE_W-1:0] prev_price   = '0;
   logic [CNT_W-1:0]   series_count = '0;
   logic [AVG_W-1:0]   gain_avg     = '0;
   logic [AVG_W-1:0]   loss_avg     = '0;

   bit idle_on = 1'b1;
   int send_gap;
   int stall_left;
   int quiet_cycles;
   int mismatch_count;
   int results_checked;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [AVG_W-1:0] sat_sum(input logic [AVG_W-1:0] a,
                                                input logic [AVG_W-1:0] b);
      logic [AVG_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[AVG_W] ? '1 : s[AVG_W-1:0];
   endfunction

   function automatic logic [AVG_W-1:0] to_fixed(input logic [AVG_W-1:0] v);
      if (v > ({AVG_W{1'b1}} >> FRAC))
         return '1;
      return v << FRAC;
   endfunction

   function automatic logic [AVG_W-1:0] window_mean(input logic [AVG_W-1:0] sum,
                                                    input logic [AVG_W-1:0] len);
      return sat_sum(to_fixed(sum / len), ((sum % len) << FRAC) / len);
   endfunction

   function automatic logic [AVG_W-1:0] wilder_smooth(input logic [AVG_W-1:0] avg,
                                                      input logic [AVG_W-1:0] x,
                                                      input logic [AVG_W-1:0] len);
      if (x >= avg)
         return avg + (x - avg) / len;
      return avg - ((avg - x) + len - 1) / len;
   endfunction

   task automatic advance_series(input price_item_type item, output index_result_type res);
      logic [CNT_W-1:0] span;
      logic [AVG_W-1:0] rise, fall, gn, ln, total;
      span = (window_len == '0) ? CNT_W'(1) : CNT_W'(window_len);
      rise = '0;
      fall = '0;
      res  = '0;
      if (item.price > prev_price)
         rise = AVG_W'(item.price - prev_price);
      else
         fall = AVG_W'(prev_price - item.price);

      if (series_count != '0 && series_count <= span) begin
         gain_avg = sat_sum(gain_avg, rise);
         loss_avg = sat_sum(loss_avg, fall);
         if (series_count == span) begin
            gain_avg = window_mean(gain_avg, AVG_W'(span));
            loss_avg = window_mean(loss_avg, AVG_W'(span));
         end
      end else if (series_count > span) begin
         gain_avg = wilder_smooth(gain_avg, to_fixed(rise), AVG_W'(span));
         loss_avg = wilder_smooth(loss_avg, to_fixed(fall), AVG_W'(span));
         res.value_valid = 1'b1;
         if (loss_avg == '0) begin
            res.rsi_value = RSI_FULL;
         end else begin
            gn = gain_avg;
            ln = loss_avg;
            while (gn >= NARROW_LIMIT || ln >= NARROW_LIMIT) begin
               gn = gn >> 1;
               ln = ln >> 1;
            end
            total = gn + ln;
            if (total == '0)
               res.rsi_value = RSI_FULL;
            else
               res.rsi_value = RSI_W'((gn * AVG_W'(RSI_FULL)) / total);
         end
      end

      if (series_count <= span)
         series_count = series_count + CNT_W'(1);
      prev_price = item.price;
      if (item.last_of_series) begin
         prev_price   = '0;
         series_count = '0;
         gain_avg     = '0;
         loss_avg     = '0;
      end
   endtask

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("[%0t] result %0d: %s expected %0d, got %0d",
                  $time, results_checked, what, want, got);
   endtask

   task automatic queue_item(input logic [PRICE_W-1:0] price, input logic last);
      price_item_type it;
      it.price          = price;
      it.last_of_series = last;
      price_queue.push_back(it);
   endtask

   task automatic queue_series(input int unsigned count, input bit close, input bit noisy);
      logic [PRICE_W-1:0] level;
      price_trend_type    trend;
      bit                 cut;
      level = $urandom;
      trend = price_trend_type'($urandom_range(0, 3));
      for (int unsigned k = 0; k < count; k++) begin
         case (trend)
            WALK:    level = level + $urandom_range(0, 4000) - 2000;
            SCATTER: level = $urandom;
            CLIMB:   level = level + $urandom_range(0, 60);
            default: level = level - $urandom_range(0, 60);
         endcase
         if ($urandom_range(0, 15) == 0)
            level = ($urandom_range(0, 1) == 1) ? '1 : '0;
         cut = (close && k == count - 1) || (noisy && $urandom_range(0, 49) == 0);
         queue_item(level, cut);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (price_queue.size() != 0 || req_bus.valid || rsi_expected.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_window(input int unsigned value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= LEN_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      window_len = LEN_W'(value);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            advance_series(on_wire, predicted);
            rsi_expected.push_back(predicted);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap != 0) begin
               send_gap      <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
               send_gap      <= $urandom_range(0, 4);
               req_bus.valid <= 1'b0;
            end else if (price_queue.size() != 0) begin
               on_wire = price_queue.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.price          <= on_wire.price;
               req_bus.last_of_series <= on_wire.last_of_series;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            if (rsi_expected.size() == 0) begin
               report_mismatch("unexpected item, rsi_value", -1, rsp_bus.rsi_value);
            end else begin
               oldest = rsi_expected.pop_front();
               if (rsp_bus.rsi_value !== oldest.rsi_value)
                  report_mismatch("rsi_value", oldest.rsi_value, rsp_bus.rsi_value);
               if (rsp_bus.value_valid !== oldest.value_valid)
                  report_mismatch("value_valid", oldest.value_valid, rsp_bus.value_valid);
            end
         end
         if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left    <= $urandom_range(0, 4);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_bus.valid && req_bus.ready)
          || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned remaining;
      int unsigned run;
      int unsigned span;
      bit          close;

      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      req_bus.valid          = 1'b0;
      req_bus.price          = '0;
      req_bus.last_of_series = 1'b0;
      rsp_bus.ready          = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // full-scale swings under the reset window
      for (int k = 0; k < 17; k++)
         queue_item((k % 2 == 1) ? '1 : '0, k == 16);
      wait_drained();

      set_window(1);
      queue_item(5, 1'b1);
      queue_item(100, 1'b0);
      queue_item(100, 1'b0);
      queue_item(100, 1'b0);
      queue_item(200, 1'b0);
      queue_item(50, 1'b1);
      queue_item(7, 1'b0);
      queue_item(3, 1'b1);
      queue_item('1, 1'b0);
      queue_item('0, 1'b0);
      queue_item('1, 1'b1);
      wait_drained();

      foreach (WINDOW_PLAN[ph]) begin
         idle_on = (ph != $size(WINDOW_PLAN) - 1) && (ph != 4);
         set_window(WINDOW_PLAN[ph]);
         span      = (WINDOW_PLAN[ph] == 0) ? 1 : WINDOW_PLAN[ph];
         remaining = (span > 100) ? 40 : span + 44;
         while (remaining > 0) begin
            run = span + 1 + $urandom_range(1, 20);
            if (run > remaining)
               run = remaining;
            close = (run < remaining) || ($urandom_range(0, 1) == 1);
            queue_series(run, close, span <= 100);
            remaining -= run;
         end
         wait_drained();
      end

      repeat (80) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> sim.f
hdl/rsi_pkg.sv
hdl/rsi_if.sv
hdl/rsi_seq.sv
hdl/rsi_ldiv.sv
hdl/rsi_dp.sv
hdl/relative_strength_index_top.sv
tb/relative_strength_index_top_test.sv
